### sv/alr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg
// shared codes, widths and handshake structs of the audio loop recorder
// ----------------------------------------------------------------------------
package alr_pkg;

  // action codes carried in the input tuser
  typedef enum logic [2:0] {
    ACT_SAMPLE  = 3'd0,
    ACT_TRIGGER = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_UNDO    = 3'd4,
    ACT_REVERSE = 3'd5,
    ACT_FADE    = 3'd6
  } action_e;

  // looper modes as reported in the result
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_REC  = 3'd1,
    MODE_PLAY = 3'd2,
    MODE_OVER = 3'd3,
    MODE_STOP = 3'd4
  } mode_e;

  // configuration register indexes
  localparam logic [2:0] REG_DRY_GAIN  = 3'd0;
  localparam logic [2:0] REG_LOOP_GAIN = 3'd1;
  localparam logic [2:0] REG_PRE_ROLL  = 3'd2;
  localparam logic [2:0] REG_XFADE     = 3'd3;
  localparam logic [2:0] REG_FADE      = 3'd4;
  localparam logic [2:0] REG_LATENCY   = 3'd5;

  // shared multiplier operand widths
  localparam int MUL_AW = 16;
  localparam int MUL_BW = 25;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // shared divider widths
  localparam int DIV_NW = 40;
  localparam int DIV_DW = 25;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

### sv/alr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module alr_mul (
  input  logic                                 clk_i,
  input  logic signed [alr_pkg::MUL_AW-1:0]    a_i,
  input  logic signed [alr_pkg::MUL_BW-1:0]    b_i,
  output logic signed [alr_pkg::MUL_PW-1:0]    prod_o
);

  logic signed [alr_pkg::MUL_PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= alr_pkg::MUL_PW'(a_i) * alr_pkg::MUL_PW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

### sv/alr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module alr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alr_pkg::div_req_t req_i,
  output alr_pkg::div_rsp_t rsp_o
);

  localparam int NW   = alr_pkg::DIV_NW;
  localparam int DW   = alr_pkg::DIV_DW;
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q, den_q;
  logic [DW:0]     trial;
  logic            fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
        quo_q  <= req_i.num;
        rem_q  <= '0;
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
        quo_q <= {quo_q[NW-2:0], fits};
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

### sv/audio_loop_recorder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_loop_recorder
// mono looper: record, overdub, undo/redo, reverse, seam crossfade, fade-out
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: action[2:0]; tdata: in_sample[15:0]
//  m_axis    out        tdata: out_sample, looper_mode, play_position,
//                              loop_frames, reversed, fading, undo, redo
//  cfg       in         cfg_we_i / cfg_idx_i / cfg_wdata_i, write only
//
//  one transaction in gives exactly one transaction out
//  sample: may run divisions on the shared divider
//    (one while fading, one for the latency offset while overdubbing)
//  trigger/stop/undo walk the loop, a read and a write per entry for copy, clear,
//    commit and swap; seam crossfade and pre-roll seeding also go entry by entry
//  the sequencer works on one transaction at a time; s_axis_tready is high
//    only while it waits; a result waits in the output register while the
//    next transaction is taken in
//  reset is immediate: the pre-roll ring reads as zero through a fill count,
//    loop stores need no clearing
// ----------------------------------------------------------------------------
module audio_loop_recorder #(
  parameter int LOOP_DEPTH    = 1048576,
  parameter int PREROLL_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // in_sample[15:0]
  input  logic [2:0]  s_axis_tuser,  // action[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_sample[15:0], looper_mode[18:16],
                                     // play_position[38:19], loop_frames[59:39],
                                     // reversed[60], fading[61], undo[62], redo[63]
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  localparam int LAW = $clog2(LOOP_DEPTH);
  localparam int CW  = LAW + 1;
  localparam int PAW = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;
  localparam int PCW = PAW + 1;
  localparam int DW  = alr_pkg::DIV_DW;
  localparam int NW  = alr_pkg::DIV_NW;
  localparam int PW  = alr_pkg::MUL_PW;

  localparam logic [CW-1:0]  LOOP_MAX = CW'(LOOP_DEPTH);
  localparam logic [PCW-1:0] PRE_MAX  = PCW'(PREROLL_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC,
    ST_S_DRY, ST_S_FMUL, ST_S_FDIV, ST_S_LMUL, ST_S_LACC, ST_S_KDIV, ST_S_ODR,
    ST_PR_RD, ST_PR_WR,
    ST_SE_SET, ST_SE_RD, ST_SE_M1, ST_SE_M2, ST_SE_DV, ST_SE_WAIT,
    ST_SW_RD, ST_SW_WR,
    ST_FINISH
  } st_e;

  typedef enum logic [1:0] {SW_COPY, SW_CLEAR, SW_COMMIT, SW_SWAP} sw_e;

  function automatic logic signed [15:0] sat16(input logic signed [41:0] v);
    if (v > 42'sd32767) return 16'sh7fff;
    else if (v < -42'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    if (v > 25'sd8388607) return 24'sh7fffff;
    else if (v < -25'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  // configuration registers
  logic [15:0] dry_q, lgain_q, lat_q;
  logic [12:0] prl_q, xfl_q;
  logic [23:0] ffr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q   <= 16'd32768;
      lgain_q <= 16'd4096;
      prl_q   <= '0;
      xfl_q   <= '0;
      ffr_q   <= 24'd24000;
      lat_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alr_pkg::REG_DRY_GAIN:  dry_q   <= cfg_wdata_i[15:0];
        alr_pkg::REG_LOOP_GAIN: lgain_q <= cfg_wdata_i[15:0];
        alr_pkg::REG_PRE_ROLL:  prl_q   <= cfg_wdata_i[12:0];
        alr_pkg::REG_XFADE:     xfl_q   <= cfg_wdata_i[12:0];
        alr_pkg::REG_FADE:      ffr_q   <= cfg_wdata_i;
        alr_pkg::REG_LATENCY:   lat_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // looper state and sequencer registers
  st_e                 st_q;
  sw_e                 sw_kind_q;
  alr_pkg::mode_e      mode_q;
  logic [2:0]          act_q;
  logic signed [15:0]  smp_q, lv_q;
  logic [LAW-1:0]      ph_q, rd_q, idx_q, es_q, tg_q;
  logic [CW-1:0]       len_q, rc_q;
  logic [23:0]         fl_q, ftot_q;
  logic                rev_q, fade_q, undo_q, redo_q, back_q;
  logic [PAW-1:0]      pos_q, ra_q;
  logic [PCW-1:0]      fill_q;
  logic                loop_on_q, fneg_q, sneg_q, zero_q, ring_vld_q;
  logic signed [35:0]  acc_q;
  logic signed [PW-1:0] nacc_q;
  logic [12:0]         n_q, xl_q;
  logic                out_vld_q;
  logic [63:0]         out_data_q;

  // memory ports
  logic                base_we, base_rea, base_reb;
  logic [LAW-1:0]      base_wa, base_raa, base_rab;
  logic signed [15:0]  base_wd, base_rda_q, base_rdb_q;
  logic                bak_we, bak_re;
  logic signed [15:0]  bak_wd, bak_rd_q;
  logic                od_we, od_re;
  logic [LAW-1:0]      od_wa, od_ra;
  logic signed [23:0]  od_wd, od_rd_q;
  logic                ring_we, ring_re;
  logic signed [15:0]  ring_rd_q;

  logic signed [15:0] base_mem [LOOP_DEPTH];
  logic signed [15:0] bak_mem  [LOOP_DEPTH];
  logic signed [23:0] od_mem   [LOOP_DEPTH];
  logic signed [15:0] ring_mem [PREROLL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (base_we) base_mem[base_wa] <= base_wd;
    if (base_rea) base_rda_q <= base_mem[base_raa];
    if (base_reb) base_rdb_q <= base_mem[base_rab];
  end

  always_ff @(posedge clk_i) begin
    if (bak_we) bak_mem[idx_q] <= bak_wd;
    if (bak_re) bak_rd_q <= bak_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (od_we) od_mem[od_wa] <= od_wd;
    if (od_re) od_rd_q <= od_mem[od_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[pos_q] <= smp_q;
    if (ring_re) ring_rd_q <= ring_mem[ra_q];
  end

  // shared arithmetic units
  logic signed [alr_pkg::MUL_AW-1:0] mul_a;
  logic signed [alr_pkg::MUL_BW-1:0] mul_b;
  logic signed [PW-1:0]              prod;
  alr_pkg::div_req_t                 div_req;
  alr_pkg::div_rsp_t                 div_rsp;

  alr_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  alr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // derived values
  logic           loop_on_c;
  logic [LAW-1:0] rd_c, tg_c;
  logic [12:0]    pre_n, x_c;
  logic [PAW-1:0] start_c;
  logic [31:0]    p32, n32;
  logic [DW:0]    rdx, kx, lx, tgx;
  logic signed [PW-1:0] fmag;
  logic signed [41:0]   seam_num, seam_mag, seam_q;
  logic signed [15:0]   fade_lv;
  logic signed [36:0]   mix_t;
  logic signed [15:0]   out_smp;

  assign loop_on_c = ((mode_q == alr_pkg::MODE_PLAY) || (mode_q == alr_pkg::MODE_OVER))
                     && (len_q != '0);
  assign rd_c = rev_q ? LAW'(len_q - CW'(1) - CW'(ph_q)) : ph_q;

  always_comb begin
    pre_n = prl_q;
    if (32'(pre_n) > 32'(PREROLL_DEPTH)) pre_n = 13'(PREROLL_DEPTH);
    if (32'(pre_n) > 32'(LOOP_DEPTH)) pre_n = 13'(LOOP_DEPTH);
    p32 = 32'(pos_q);
    n32 = 32'(pre_n);
    start_c = PAW'((p32 >= n32) ? (p32 - n32) : (p32 + 32'(PREROLL_DEPTH) - n32));
    // seam length limited to half the loop
    x_c = (32'(xfl_q) > 32'(len_q >> 1)) ? 13'(len_q >> 1) : xfl_q;
    // overdub target shifted back by latency mod loop length
    rdx = (DW+1)'(rd_q);
    kx  = (DW+1)'(div_rsp.rem);
    lx  = (DW+1)'(len_q);
    tgx = (rdx >= kx) ? (rdx - kx) : (lx + rdx - kx);
    tg_c = LAW'(tgx);
    fmag = (prod < 0) ? -prod : prod;
    fade_lv = fneg_q ? -16'(div_rsp.quo) : 16'(div_rsp.quo);
    seam_num = ((42'(nacc_q) + 42'(prod)) <<< 1) + 42'(xl_q);
    seam_mag = (seam_num < 0) ? -seam_num : seam_num;
    seam_q = sneg_q ? -(42'(div_rsp.quo) + 42'(div_rsp.rem != '0)) : 42'(div_rsp.quo);
    // round half up, saturate to q1.15
    mix_t = 37'(acc_q) + 37'sd16384;
    if (mix_t >= 37'sd1073741824) out_smp = 16'sh7fff;
    else if (mix_t < -37'sd1073741824) out_smp = 16'sh8000;
    else out_smp = mix_t[30:15];
  end

  // memory, multiplier and divider control per sequencer step
  always_comb begin
    base_we  = 1'b0;
    base_wa  = idx_q;
    base_wd  = '0;
    base_rea = 1'b0;
    base_raa = idx_q;
    base_reb = 1'b0;
    base_rab = es_q + idx_q;
    bak_we   = 1'b0;
    bak_wd   = base_rda_q;
    bak_re   = 1'b0;
    od_we    = 1'b0;
    od_wa    = idx_q;
    od_wd    = '0;
    od_re    = 1'b0;
    od_ra    = idx_q;
    ring_we  = 1'b0;
    ring_re  = 1'b0;
    mul_a    = smp_q;
    mul_b    = {9'd0, dry_q};
    div_req  = '0;
    unique case (st_q)
      ST_EXEC: begin
        if (act_q == alr_pkg::ACT_SAMPLE) begin
          ring_we = 1'b1;
          if ((mode_q == alr_pkg::MODE_REC) && (rc_q < LOOP_MAX)) begin
            base_we = 1'b1;
            base_wa = LAW'(rc_q);
            base_wd = smp_q;
          end
          if (loop_on_c) begin
            base_rea = 1'b1;
            base_raa = rd_c;
          end
        end
      end
      ST_S_DRY: begin
        mul_a = base_rda_q;
        mul_b = {1'b0, fl_q};
      end
      ST_S_FMUL: begin
        div_req.start = 1'b1;
        div_req.num   = NW'(fmag);
        div_req.den   = DW'(ftot_q);
      end
      ST_S_LMUL: begin
        mul_a = lv_q;
        mul_b = {9'd0, lgain_q};
      end
      ST_S_LACC: begin
        if (mode_q == alr_pkg::MODE_OVER) begin
          div_req.start = 1'b1;
          div_req.num   = NW'(lat_q);
          div_req.den   = DW'(len_q);
        end
      end
      ST_S_KDIV: begin
        if (div_rsp.done) begin
          od_re = 1'b1;
          od_ra = tg_c;
        end
      end
      ST_S_ODR: begin
        od_we = 1'b1;
        od_wa = tg_q;
        od_wd = sat24(25'(od_rd_q) + 25'(smp_q));
      end
      ST_PR_RD: ring_re = 1'b1;
      ST_PR_WR: begin
        base_we = 1'b1;
        base_wd = ring_vld_q ? ring_rd_q : 16'sd0;
      end
      ST_SE_RD: begin
        base_rea = 1'b1;
        base_reb = 1'b1;
      end
      ST_SE_M1: begin
        mul_a = base_rda_q;
        mul_b = 25'(idx_q);
      end
      ST_SE_M2: begin
        mul_a = base_rdb_q;
        mul_b = 25'(xl_q) - 25'(idx_q);
      end
      ST_SE_DV: begin
        div_req.start = 1'b1;
        div_req.num   = NW'(seam_mag);
        div_req.den   = DW'({xl_q, 1'b0});
      end
      ST_SE_WAIT: begin
        if (div_rsp.done) begin
          base_we = 1'b1;
          base_wd = sat16(seam_q);
        end
      end
      ST_SW_RD: begin
        base_rea = 1'b1;
        od_re    = 1'b1;
        bak_re   = 1'b1;
      end
      ST_SW_WR: begin
        unique case (sw_kind_q)
          SW_COPY: begin
            bak_we = 1'b1;
            od_we  = 1'b1;
          end
          SW_CLEAR: od_we = 1'b1;
          SW_COMMIT: begin
            base_we = 1'b1;
            base_wd = sat16(42'(base_rda_q) + 42'(od_rd_q));
          end
          SW_SWAP: begin
            base_we = 1'b1;
            base_wd = bak_rd_q;
            bak_we  = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      sw_kind_q  <= SW_CLEAR;
      mode_q     <= alr_pkg::MODE_IDLE;
      act_q      <= '0;
      smp_q      <= '0;
      lv_q       <= '0;
      ph_q       <= '0;
      rd_q       <= '0;
      idx_q      <= '0;
      es_q       <= '0;
      tg_q       <= '0;
      len_q      <= '0;
      rc_q       <= '0;
      fl_q       <= '0;
      ftot_q     <= '0;
      rev_q      <= 1'b0;
      fade_q     <= 1'b0;
      undo_q     <= 1'b0;
      redo_q     <= 1'b0;
      back_q     <= 1'b0;
      pos_q      <= '0;
      ra_q       <= '0;
      fill_q     <= '0;
      loop_on_q  <= 1'b0;
      fneg_q     <= 1'b0;
      sneg_q     <= 1'b0;
      zero_q     <= 1'b0;
      ring_vld_q <= 1'b0;
      acc_q      <= '0;
      nacc_q     <= '0;
      n_q        <= '0;
      xl_q       <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (m_axis_tready) out_vld_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            act_q <= s_axis_tuser;
            smp_q <= s_axis_tdata;
            st_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          loop_on_q <= loop_on_c;
          rd_q      <= rd_c;
          acc_q     <= '0;
          idx_q     <= '0;
          st_q      <= ST_FINISH;
          unique case (act_q)
            alr_pkg::ACT_SAMPLE: begin
              pos_q <= (32'(pos_q) == 32'(PREROLL_DEPTH - 1)) ? '0 : pos_q + PAW'(1);
              if (fill_q != PRE_MAX) fill_q <= fill_q + PCW'(1);
              if ((mode_q == alr_pkg::MODE_REC) && (rc_q < LOOP_MAX)) rc_q <= rc_q + CW'(1);
              st_q <= ST_S_DRY;
            end
            alr_pkg::ACT_TRIGGER: begin
              unique case (mode_q)
                alr_pkg::MODE_IDLE: begin
                  // new take, seeded from the pre-roll ring
                  rc_q   <= CW'(pre_n);
                  len_q  <= '0;
                  ph_q   <= '0;
                  fade_q <= 1'b0;
                  undo_q <= 1'b0;
                  redo_q <= 1'b0;
                  back_q <= 1'b0;
                  mode_q <= alr_pkg::MODE_REC;
                  ra_q   <= start_c;
                  n_q    <= pre_n;
                  if (pre_n != '0) st_q <= ST_PR_RD;
                end
                alr_pkg::MODE_REC: begin
                  if (rc_q == '0) begin
                    mode_q <= alr_pkg::MODE_IDLE;
                  end else begin
                    len_q  <= rc_q;
                    ph_q   <= '0;
                    mode_q <= alr_pkg::MODE_PLAY;
                    zero_q <= 1'b1;
                    st_q   <= ST_SE_SET;
                  end
                end
                alr_pkg::MODE_PLAY: begin
                  // snapshot for undo and a fresh overdub layer
                  redo_q    <= 1'b0;
                  undo_q    <= 1'b1;
                  back_q    <= 1'b1;
                  mode_q    <= alr_pkg::MODE_OVER;
                  sw_kind_q <= SW_COPY;
                  st_q      <= ST_SW_RD;
                end
                alr_pkg::MODE_OVER: begin
                  mode_q    <= alr_pkg::MODE_PLAY;
                  sw_kind_q <= SW_COMMIT;
                  st_q      <= ST_SW_RD;
                end
                alr_pkg::MODE_STOP: begin
                  if (len_q != '0) begin
                    fade_q <= 1'b0;
                    mode_q <= alr_pkg::MODE_PLAY;
                  end
                end
                default: ;
              endcase
            end
            alr_pkg::ACT_STOP: begin
              fade_q <= 1'b0;
              priority if (mode_q == alr_pkg::MODE_REC) begin
                if (rc_q == '0) begin
                  mode_q <= alr_pkg::MODE_IDLE;
                end else begin
                  len_q  <= rc_q;
                  ph_q   <= '0;
                  mode_q <= alr_pkg::MODE_STOP;
                  zero_q <= 1'b0;
                  st_q   <= ST_SE_SET;
                end
              end else if (mode_q == alr_pkg::MODE_OVER) begin
                mode_q    <= alr_pkg::MODE_STOP;
                sw_kind_q <= SW_COMMIT;
                st_q      <= ST_SW_RD;
              end else if (mode_q == alr_pkg::MODE_PLAY) begin
                mode_q <= alr_pkg::MODE_STOP;
              end
            end
            alr_pkg::ACT_CLEAR: begin
              mode_q <= alr_pkg::MODE_IDLE;
              rc_q   <= '0;
              len_q  <= '0;
              ph_q   <= '0;
              fade_q <= 1'b0;
              undo_q <= 1'b0;
              redo_q <= 1'b0;
              back_q <= 1'b0;
            end
            alr_pkg::ACT_UNDO: begin
              if (back_q && (len_q != '0)) begin
                undo_q    <= !undo_q;
                redo_q    <= undo_q;
                sw_kind_q <= SW_SWAP;
                st_q      <= ST_SW_RD;
              end
            end
            alr_pkg::ACT_REVERSE: rev_q <= !rev_q;
            alr_pkg::ACT_FADE: begin
              if ((mode_q == alr_pkg::MODE_PLAY) || (mode_q == alr_pkg::MODE_OVER)) begin
                ftot_q <= ffr_q;
                fl_q   <= ffr_q;
                fade_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        // sample path
        ST_S_DRY: begin
          acc_q <= 36'(prod);
          if (!loop_on_q) begin
            st_q <= ST_FINISH;
          end else if (fade_q) begin
            if ((fl_q != '0) && (ftot_q != '0)) begin
              st_q <= ST_S_FMUL;
            end else begin
              // fade finished: mute and stop
              lv_q   <= '0;
              fl_q   <= '0;
              fade_q <= 1'b0;
              mode_q <= alr_pkg::MODE_STOP;
              st_q   <= ST_S_LMUL;
            end
          end else begin
            lv_q <= base_rda_q;
            st_q <= ST_S_LMUL;
          end
        end
        ST_S_FMUL: begin
          fneg_q <= prod < 0;
          st_q   <= ST_S_FDIV;
        end
        ST_S_FDIV: begin
          if (div_rsp.done) begin
            lv_q <= fade_lv;
            fl_q <= fl_q - 24'd1;
            st_q <= ST_S_LMUL;
          end
        end
        ST_S_LMUL: st_q <= ST_S_LACC;
        ST_S_LACC: begin
          acc_q <= acc_q + (36'(prod) <<< 3);
          ph_q  <= ((32'(ph_q) + 32'd1) == 32'(len_q)) ? '0 : ph_q + LAW'(1);
          st_q  <= (mode_q == alr_pkg::MODE_OVER) ? ST_S_KDIV : ST_FINISH;
        end
        ST_S_KDIV: begin
          if (div_rsp.done) begin
            tg_q <= tg_c;
            st_q <= ST_S_ODR;
          end
        end
        ST_S_ODR: st_q <= ST_FINISH;
        // pre-roll seed copy
        ST_PR_RD: begin
          ring_vld_q <= PCW'(ra_q) < fill_q;
          st_q       <= ST_PR_WR;
        end
        ST_PR_WR: begin
          ra_q  <= (32'(ra_q) == 32'(PREROLL_DEPTH - 1)) ? '0 : ra_q + PAW'(1);
          idx_q <= idx_q + LAW'(1);
          st_q  <= ((32'(idx_q) + 32'd1) == 32'(n_q)) ? ST_FINISH : ST_PR_RD;
        end
        // seam crossfade over the loop head
        ST_SE_SET: begin
          xl_q <= x_c;
          es_q <= LAW'(len_q - CW'(x_c));
          if (x_c != '0) begin
            st_q <= ST_SE_RD;
          end else if (zero_q) begin
            sw_kind_q <= SW_CLEAR;
            st_q      <= ST_SW_RD;
          end else begin
            st_q <= ST_FINISH;
          end
        end
        ST_SE_RD: st_q <= ST_SE_M1;
        ST_SE_M1: st_q <= ST_SE_M2;
        ST_SE_M2: begin
          nacc_q <= prod;
          st_q   <= ST_SE_DV;
        end
        ST_SE_DV: begin
          sneg_q <= seam_num < 0;
          st_q   <= ST_SE_WAIT;
        end
        ST_SE_WAIT: begin
          if (div_rsp.done) begin
            if ((32'(idx_q) + 32'd1) == 32'(xl_q)) begin
              idx_q <= '0;
              if (zero_q) begin
                sw_kind_q <= SW_CLEAR;
                st_q      <= ST_SW_RD;
              end else begin
                st_q <= ST_FINISH;
              end
            end else begin
              idx_q <= idx_q + LAW'(1);
              st_q  <= ST_SE_RD;
            end
          end
        end
        // whole-loop sweeps
        ST_SW_RD: st_q <= ST_SW_WR;
        ST_SW_WR: begin
          if ((32'(idx_q) + 32'd1) == 32'(len_q)) begin
            st_q <= ST_FINISH;
          end else begin
            idx_q <= idx_q + LAW'(1);
            st_q  <= ST_SW_RD;
          end
        end
        ST_FINISH: begin
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q  <= 1'b1;
            out_data_q <= {redo_q, undo_q, fade_q, rev_q, 21'(len_q), 20'(ph_q),
                           3'(mode_q), out_smp};
            st_q       <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // playhead stays inside the loop
  a_ph_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (CW'(ph_q) < len_q))
    else $error("playhead beyond loop length");

  // take never grows past the store
  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= LOOP_MAX)
    else $error("record count beyond loop depth");

  // divider is started only when free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a fade runs only while the loop plays
  a_fade_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_IDLE) && fade_q) |->
      ((mode_q == alr_pkg::MODE_PLAY) || (mode_q == alr_pkg::MODE_OVER)))
    else $error("fade active outside playback");

  // pre-roll fill count saturates at ring depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= PRE_MAX)
    else $error("pre-roll fill count overflow");

endmodule
